### rtl/core/lvr_pkg.sv
// Shared types and constants of the varispeed tape reader.
`timescale 1ns / 1ps
package lvr_pkg;

    localparam int ADDR_W   = 12;
    localparam int SAMP_W   = 24;
    localparam int PHASE_W  = 16;
    localparam int SPEED_W  = 20;
    localparam int COEF_W   = 19;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 24;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] MAC_LAST_READ = 3'd3;
    localparam logic [2:0] MAC_END       = 3'd5;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_COEF0 = 6'b000010,
        ST_COEF1 = 6'b000100,
        ST_COEF2 = 6'b001000,
        ST_MAC   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic       do_write;
        logic       do_start;
        logic       latch_speed;
        logic       do_coef0;
        logic       do_coef1;
        logic       do_coef2;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       do_finish;
    } cmd_t;

    typedef struct packed {
        logic out_valid;
    } status_t;

endpackage

### rtl/core/lvr_ctrl.sv
// Sequencer of the varispeed tape reader.
`timescale 1ns / 1ps
module lvr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      in_opcode,
    input  logic            out_ready,
    input  lvr_pkg::status_t status,
    output logic            in_ready,
    output lvr_pkg::cmd_t   cmd
);
    import lvr_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 3'd0;
                if (in_valid)
                begin
                    if (in_opcode == OP_WRITE)
                        cmd.do_write = 1'b1;
                    else if (in_opcode == OP_START)
                        cmd.do_start = 1'b1;
                    else if (in_opcode == OP_READ)
                    begin
                        cmd.latch_speed = 1'b1;
                        state_next      = ST_COEF0;
                    end
                end
            end
            ST_COEF0:
            begin
                cmd.do_coef0 = 1'b1;
                state_next   = ST_COEF1;
            end
            ST_COEF1:
            begin
                cmd.do_coef1 = 1'b1;
                state_next   = ST_COEF2;
            end
            ST_COEF2:
            begin
                cmd.do_coef2 = 1'b1;
                state_next   = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.rd_en  = (cnt_reg <= MAC_LAST_READ);
                cmd.rd_sel = cnt_reg[1:0];
                cnt_next   = cnt_reg + 3'd1;
                if (cnt_reg == MAC_END)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_valid || out_ready)
                begin
                    cmd.do_finish = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/core/lvr_datapath.sv
// Tape memory, Lagrange weights, multiply-accumulate and output register.
`timescale 1ns / 1ps
module lvr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lvr_pkg::cmd_t                 cmd,
    input  logic [lvr_pkg::ADDR_W-1:0]    address,
    input  logic signed [lvr_pkg::SAMP_W-1:0]  sample_in,
    input  logic [lvr_pkg::PHASE_W-1:0]   start_phase,
    input  logic signed [lvr_pkg::SPEED_W-1:0] speed,
    input  logic                          out_ready,
    output lvr_pkg::status_t              status,
    output logic signed [lvr_pkg::SAMP_W-1:0]  sample_out
);
    import lvr_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;
    localparam logic signed [COEF_W-1:0] ONE_Q = 19'sd65536;
    localparam logic signed [37:0] HALF_Q = 38'sd32768;
    localparam logic signed [37:0] FULL_Q = 38'sd65536;
    localparam logic signed [37:0] THREE_Q = 38'sd196608;
    localparam logic signed [17:0] DIV6_BIAS = 18'sd49152;
    localparam logic [15:0] RECIP6 = 16'd43691;
    localparam logic signed [COEF_W-1:0] DIV6_OFFS = 19'sd8192;
    localparam logic signed [45:0] ROUND_OUT = 46'sd32768;
    localparam logic signed [29:0] SAT_HI = 30'sd8388607;
    localparam logic signed [29:0] SAT_LO = -30'sd8388608;

    logic signed [SAMP_W-1:0] tape [DEPTH];

    logic [ADDR_W-1:0]         pos_reg;
    logic [PHASE_W-1:0]        phase_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [COEF_W-1:0]  a_reg, b_reg, c_reg;
    logic signed [37:0]        t_reg [4];
    logic signed [COEF_W-1:0]  k_reg [4];
    logic signed [SAMP_W-1:0]  rdata_reg;
    logic                      rd_v_reg;
    logic [1:0]                rd_sel_reg;
    logic signed [42:0]        prod_reg;
    logic                      prod_v_reg;
    logic signed [45:0]        acc_reg;
    logic signed [SAMP_W-1:0]  out_reg;
    logic                      out_valid_reg;

    logic signed [COEF_W-1:0] pe, pm1, pp1, pm2;
    logic signed [37:0]       pa, pb, pc;
    logic signed [COEF_W-1:0] k_next [4];
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [45:0]       rnd;
    logic signed [29:0]       res;
    logic signed [SAMP_W-1:0] sat;
    logic signed [20:0]       ph;
    logic [ADDR_W-1:0]        whole;

    // floor(w/6) by reciprocal; the bias keeps the operand positive and below 2^17
    function automatic logic signed [COEF_W-1:0] div6(input logic signed [17:0] w);
        logic signed [17:0] u;
        logic [32:0]        m;
        u = w + DIV6_BIAS;
        m = u[16:0] * RECIP6;
        return $signed({4'b0, m[32:18]}) - DIV6_OFFS;
    endfunction

    assign pe  = $signed({3'b0, phase_reg});
    assign pm1 = pe - ONE_Q;
    assign pp1 = pe + ONE_Q;
    assign pm2 = pe - (ONE_Q <<< 1);

    assign pa = 38'(pe  * pm1) + HALF_Q;
    assign pb = 38'(pp1 * pm1) + HALF_Q;
    assign pc = 38'(pp1 * pe)  + HALF_Q;

    always_comb
    begin
        logic signed [37:0] s0, s1, s2, s3;
        s0 = (t_reg[0] + THREE_Q) >>> 16;
        s1 = (t_reg[1] + FULL_Q) >>> 17;
        s2 = (t_reg[2] + FULL_Q) >>> 17;
        s3 = (t_reg[3] + THREE_Q) >>> 16;
        k_next[0] = div6(s0[17:0]);
        k_next[1] = s1[COEF_W-1:0];
        k_next[2] = s2[COEF_W-1:0];
        k_next[3] = div6(s3[17:0]);
    end

    assign rd_addr = pos_reg + {{(ADDR_W-2){1'b0}}, cmd.rd_sel} - {{(ADDR_W-1){1'b0}}, 1'b1};

    assign rnd = (acc_reg + ROUND_OUT) >>> 16;
    assign res = rnd[29:0];
    always_comb
    begin
        if (res > SAT_HI)
            sat = SAT_HI[SAMP_W-1:0];
        else if (res < SAT_LO)
            sat = SAT_LO[SAMP_W-1:0];
        else
            sat = res[SAMP_W-1:0];
    end

    assign ph    = $signed({5'b0, phase_reg}) + 21'(speed_reg);
    assign whole = {{(ADDR_W-5){ph[20]}}, ph[20:16]};

    // single-port tape
    always_ff @(posedge clk)
    begin
        if (cmd.do_write)
            tape[address] <= sample_in;
        else if (cmd.rd_en)
            rdata_reg <= tape[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_speed)
            speed_reg <= speed;
        if (cmd.do_coef0)
        begin
            a_reg <= pa[34:16];
            b_reg <= pb[34:16];
            c_reg <= pc[34:16];
        end
        if (cmd.do_coef1)
        begin
            t_reg[0] <= 38'(-a_reg * pm2);
            t_reg[1] <= 38'(b_reg * pm2);
            t_reg[2] <= 38'(-c_reg * pm2);
            t_reg[3] <= 38'(c_reg * pm1);
        end
        if (cmd.do_coef2)
            k_reg <= k_next;
        if (rd_v_reg)
            prod_reg <= 43'(rdata_reg * k_reg[rd_sel_reg]);
        if (cmd.do_coef0)
            acc_reg <= '0;
        else if (prod_v_reg)
            acc_reg <= acc_reg + 46'(prod_reg);
        if (cmd.do_finish)
            out_reg <= sat;
        rd_sel_reg <= cmd.rd_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= '0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= cmd.rd_en;
            prod_v_reg <= rd_v_reg;
            if (cmd.do_start)
            begin
                pos_reg   <= address;
                phase_reg <= start_phase;
            end
            else if (cmd.do_finish)
            begin
                pos_reg   <= pos_reg + whole;
                phase_reg <= ph[15:0];
            end
            if (cmd.do_finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.out_valid = out_valid_reg;
    assign sample_out       = out_reg;

endmodule

### rtl/core/lagrange_varispeed_reader.sv
// Top level of the varispeed tape reader with cubic Lagrange interpolation.
// Write and start transfers are taken in the idle state.
// A read transfer runs from acceptance to the loaded output register through weight
// arithmetic (COEF0, COEF1, COEF2), tape reads and MAC through one port and one
// multiplier (MAC), DONE to finish. Next input only once back in idle; held output stalls.
// Reset (rst_n, async, active low) clears position, phase and control; tape is not cleared.
`timescale 1ns / 1ps
module lagrange_varispeed_reader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[1:0], address[13:2], sample_in[37:14], start_phase[53:38], speed[73:54]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sample_out[23:0]
    output logic [23:0] m_tdata
);
    import lvr_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic signed [SAMP_W-1:0] sample_out;

    lvr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_opcode (s_tdata[1:0]),
        .out_ready (m_tready),
        .status    (status),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    lvr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .address     (s_tdata[13:2]),
        .sample_in   ($signed(s_tdata[37:14])),
        .start_phase (s_tdata[53:38]),
        .speed       ($signed(s_tdata[73:54])),
        .out_ready   (m_tready),
        .status      (status),
        .sample_out  (sample_out)
    );

    assign m_tvalid = status.out_valid;
    assign m_tdata  = sample_out;

endmodule

### dv/lagrange_varispeed_reader_test.sv
// Self-checking testbench for the varispeed tape reader.
`timescale 1ns / 1ps
module lagrange_varispeed_reader_test;
    import lvr_pkg::*;

    localparam int DEPTH = 4096;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [79:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [23:0] m_tdata;

    lagrange_varispeed_reader uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: own copy of tape, position and phase
    logic signed [23:0] tape_copy [DEPTH];
    logic [11:0]        play_pos;
    logic [15:0]        play_phase;
    logic [23:0]        samples_due [$];
    int                 fail_count;
    int                 idle_cycles;
    int                 ready_gap;

    function automatic longint rdiv(longint v, longint d);
        longint t;
        t = v + d / 2;
        if (t >= 0)
            return t / d;
        return -((-t + d - 1) / d);
    endfunction

    // Apply one transfer to the predictor; queue the sample a read produces.
    task automatic predict_transfer(input logic [79:0] item);
        logic [1:0]  op;
        longint p, s, a, b, c, acc, res, ph, whole;
        longint k [4];
        op = item[1:0];
        s = 65536;
        if (op == OP_WRITE)
        begin
            tape_copy[item[13:2]] = item[37:14];
        end
        else if (op == OP_START)
        begin
            play_pos = item[13:2];
            play_phase = item[53:38];
        end
        else if (op == OP_READ)
        begin
            p = play_phase;
            a = rdiv(p * (p - s), s);
            b = rdiv((p + s) * (p - s), s);
            c = rdiv((p + s) * p, s);
            k[0] = rdiv(-a * (p - 2 * s), 6 * s);
            k[1] = rdiv(b * (p - 2 * s), 2 * s);
            k[2] = rdiv(-c * (p - 2 * s), 2 * s);
            k[3] = rdiv(c * (p - s), 6 * s);
            acc = 0;
            for (int i = 0; i < 4; i++)
                acc += longint'(tape_copy[12'(play_pos - 1 + i)]) * k[i];
            res = rdiv(acc, s);
            if (res > 8388607)
                res = 8388607;
            if (res < -8388608)
                res = -8388608;
            samples_due.push_back(res[23:0]);
            ph = p + longint'($signed(item[73:54]));
            whole = (ph >= 0) ? ph / s : -((-ph + s - 1) / s);
            play_phase = 16'(ph - whole * s);
            play_pos = 12'(longint'(play_pos) + whole);
        end
    endtask

    function automatic logic [79:0] pack_item(logic [1:0] op, logic [11:0] addr,
                                              logic [23:0] smp, logic [15:0] ph,
                                              logic [19:0] spd);
        return {6'd0, spd, ph, smp, addr, op};
    endfunction

    // Short gaps mostly, an occasional long one, some runs with none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic [79:0] item);
        int gap;
        gap = pick_gap();
        s_tvalid = 1'b0;
        repeat (gap)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = item;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_transfer(item);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Stall the result side for random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            ready_gap = 0;
        end
        else if (ready_gap > 0)
        begin
            m_tready <= 1'b0;
            ready_gap--;
        end
        else
        begin
            m_tready <= 1'b1;
            ready_gap = pick_gap();
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (samples_due.size() == 0)
            begin
                $display("%0t: unexpected sample, expected none, actual %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                if (m_tdata !== samples_due[0])
                begin
                    $display("%0t: sample_out mismatch, expected %h, actual %h",
                             $time, samples_due[0], m_tdata);
                    fail_count++;
                end
                void'(samples_due.pop_front());
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Directed table: extremes, every opcode, tape edges, saturation, unused opcode.
    // The expected column is used only where a row's result is obvious (known is 1); else known is 0 or -1.
    typedef struct {
        logic [79:0] item;
        int          known;
        logic [23:0] sample;
    } dir_row_t;

    dir_row_t dir_rows [$];

    task automatic add_row(logic [79:0] item, int known, logic [23:0] smp);
        dir_row_t r;
        r.item = item;
        r.known = known;
        r.sample = smp;
        dir_rows.push_back(r);
    endtask

    task automatic write_window(int base, logic [23:0] v);
        for (int i = -1; i <= 2; i++)
            add_row(pack_item(OP_WRITE, 12'(base + i), v, 16'h0, 20'h0), 0, '0);
    endtask

    // Random part: mostly fill a window, start, then a run of reads inside it
    task automatic random_burst(inout int budget);
        int base, len, span;
        logic [1:0] op;
        logic [19:0] spd;
        base = $urandom_range(0, DEPTH - 1);
        span = $urandom_range(8, 24);
        for (int i = -2; i < span + 4; i++)
        begin
            send_item(pack_item(OP_WRITE, 12'(base + i), 24'($urandom), 16'h0, 20'($urandom)));
            budget--;
        end
        send_item(pack_item(OP_START, 12'(base), 24'($urandom), 16'($urandom), 20'($urandom)));
        budget--;
        len = $urandom_range(3, 12);
        for (int j = 0; j < len; j++)
        begin
            // speeds kept small so reads stay inside the written window
            spd = 20'($urandom_range(0, 131072)) - 20'd32768;
            if ($urandom_range(0, 9) == 0)
                op = 2'd3;
            else
                op = OP_READ;
            send_item(pack_item(op, 12'($urandom), 24'($urandom), 16'($urandom), spd));
            budget--;
            // stop if the window edge is near
            if (play_pos < 12'(base) || play_pos > 12'(base + span))
                break;
        end
    endtask

    initial
    begin
        int budget;
        fail_count = 0;
        idle_cycles = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        rst_n = 1'b0;
        play_pos = '0;
        play_phase = '0;
        for (int i = 0; i < DEPTH; i++)
            tape_copy[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Constant window: interpolation of a constant returns it at phase zero
        write_window(0, 24'h7FFFFF);
        add_row(pack_item(OP_READ, 12'h0, 24'h0, 16'h0, 20'h0), 1, 24'h7FFFFF);
        write_window(4095, 24'h800000);
        add_row(pack_item(OP_START, 12'hFFF, 24'h0, 16'h0, 20'h0), 0, '0);
        add_row(pack_item(OP_READ, 12'h0, 24'h0, 16'h0, 20'h0), 1, 24'h800000);
        // Overshoot: extremes low, high, high, low; a read at mid phase saturates
        add_row(pack_item(OP_WRITE, 12'd100, 24'h800000, 16'h0, 20'h0), 0, '0);
        add_row(pack_item(OP_WRITE, 12'd101, 24'h7FFFFF, 16'h0, 20'h0), 0, '0);
        add_row(pack_item(OP_WRITE, 12'd102, 24'h7FFFFF, 16'h0, 20'h0), 0, '0);
        add_row(pack_item(OP_WRITE, 12'd103, 24'h800000, 16'h0, 20'h0), 0, '0);
        add_row(pack_item(OP_START, 12'd101, 24'h0, 16'hFFFF, 20'h7FFFF), 0, '0);
        add_row(pack_item(OP_READ, 12'hFFF, 24'hFFFFFF, 16'hFFFF, 20'h80000), -1, '0);
        add_row(pack_item(OP_START, 12'd101, 24'h0, 16'h8000, 20'h0), 0, '0);
        add_row(pack_item(2'd3, 12'hFFF, 24'hFFFFFF, 16'hFFFF, 20'hFFFFF), 0, '0);
        add_row(pack_item(OP_READ, 12'h0, 24'h0, 16'h0, 20'h80000), -1, '0);

        foreach (dir_rows[r])
        begin
            send_item(dir_rows[r].item);
            if (dir_rows[r].known == 1 && samples_due[$] !== dir_rows[r].sample)
            begin
                $display("%0t: directed row %0d, expected %h, predicted %h",
                         $time, r, dir_rows[r].sample, samples_due[$]);
                fail_count++;
            end
        end

        // sender holds off until every directed result is back
        while (samples_due.size() != 0)
            @(negedge clk);

        budget = 1600;
        while (budget > 0)
        begin
            random_burst(budget);
            if ($urandom_range(0, 19) == 0)
            begin
                // sender holds off until every result is back
                while (samples_due.size() != 0)
                    @(negedge clk);
            end
        end

        while (samples_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
